[rtl/qfr_pkg.sv]
`default_nettype none
package qfr_pkg;

   // Number format of every matrix element and quaternion part
   localparam int FRAC_BITS = 14;
   localparam int DW        = 16;

   // Clamped root argument, radicand (even width) and root
   localparam int ARG_W  = $clog2(3 * (2 ** (DW - 1) - 1) + 2 ** FRAC_BITS + 1);
   localparam int SUM_W  = ARG_W + 1;
   localparam int RAD_W  = ARG_W + FRAC_BITS + ((ARG_W + FRAC_BITS) % 2);
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;

   // Off-diagonal sum or difference, quotient and divisor
   localparam int D_W    = DW + 1;
   localparam int QB     = DW + 1;
   localparam int DIV_W  = ROOT_W + 1;
   localparam int NUM_W  = ((D_W + FRAC_BITS > ROOT_W) ? D_W + FRAC_BITS : ROOT_W) + 1;
   localparam int CMP_W  = NUM_W + DIV_W;
   localparam int HALF_W = ROOT_W + DW;

   localparam logic [DW-1:0] SAT_MAX = DW'(2 ** (DW - 1) - 1);
   localparam logic [DW-1:0] SAT_MIN = DW'(2 ** (DW - 1));
   localparam logic [DW-1:0] ONE_SAT = (FRAC_BITS >= DW - 1) ? SAT_MAX : DW'(2 ** FRAC_BITS);
   localparam logic [QB-1:0] QPOS_LIM = QB'(2 ** (DW - 1) - 1);
   localparam logic [QB-1:0] QNEG_LIM = QB'(2 ** (DW - 1));
   localparam logic [HALF_W-1:0] HPOS_LIM = HALF_W'(2 ** (DW - 1) - 1);

   // Which quaternion part comes from the root
   typedef enum logic [1:0] {SEL_W, SEL_X, SEL_Y, SEL_Z} sel_type;

   // The three other parts fill the free slots in w, x, y, z order
   typedef struct packed {
      sel_type               sel;
      logic signed [D_W-1:0] da;
      logic signed [D_W-1:0] db;
      logic signed [D_W-1:0] dc;
   } ctx_type;

   typedef struct packed {
      logic [ARG_W-1:0] arg;
      ctx_type          ctx;
   } front_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
      ctx_type           ctx;
   } sq_state_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      ctx_type           ctx;
   } root_type;

   typedef struct packed {
      logic [DIV_W:0]  rem;
      logic [QB-1:0]   quo;
      logic [QB-1:0]   num_lo;
      logic            ovf;
      logic            neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [2:0] lane;
      logic [DIV_W-1:0]   dvs;
      logic [ROOT_W-1:0]  root;
      sel_type            sel;
   } div_state_type;

   typedef struct packed {
      logic [2:0][QB-1:0] quo;
      logic [2:0]         ovf;
      logic [2:0]         neg;
      logic [ROOT_W-1:0]  root;
      sel_type            sel;
   } quo_type;

   // One root digit: bring down two radicand bits, try (root << 2) | 1
   function automatic sq_state_type sqrt_step(input sq_state_type s);
      sq_state_type     n;
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      n     = s;
      rem2  = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
      trial = {1'b0, s.root, 2'b01};
      if (rem2 >= trial) begin
         n.rem  = rem2 - trial;
         n.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = rem2;
         n.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      n.rad = {s.rad[RAD_W-3:0], 2'b00};
      return n;
   endfunction

   // One quotient bit of restoring division
   function automatic div_lane_type div_step(input div_lane_type s, input logic [DIV_W-1:0] d);
      div_lane_type   n;
      logic [DIV_W:0] rem2;
      n    = s;
      rem2 = {s.rem[DIV_W-1:0], s.num_lo[QB-1]};
      if (rem2 >= {1'b0, d}) begin
         n.rem = rem2 - {1'b0, d};
         n.quo = {s.quo[QB-2:0], 1'b1};
      end else begin
         n.rem = rem2;
         n.quo = {s.quo[QB-2:0], 1'b0};
      end
      n.num_lo = {s.num_lo[QB-2:0], 1'b0};
      return n;
   endfunction

   // Apply sign and saturate a quotient magnitude
   function automatic logic [DW-1:0] sat_quo(input logic [QB-1:0] quo, input logic ovf,
                                             input logic neg);
      logic [QB-1:0] nq;
      nq = -quo;
      if (!neg) begin
         if (ovf || quo > QPOS_LIM) return SAT_MAX;
         return quo[DW-1:0];
      end
      if (ovf || quo > QNEG_LIM) return SAT_MIN;
      return nq[DW-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/qfr_front.sv]
`default_nettype none
module qfr_front
   import qfr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [9*DW-1:0] in_mat,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output front_type            out_data
);

   logic                   v_ff;
   front_type              data_ff;
   front_type              data_in;
   logic signed [SUM_W-1:0] m [9];
   logic signed [D_W-1:0]   e [9];
   logic signed [SUM_W-1:0] tr;
   logic signed [SUM_W-1:0] arg_s;
   logic signed [SUM_W-1:0] one_s;

   assign one_s = SUM_W'(2 ** FRAC_BITS);

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m[i] = SUM_W'(signed'(in_mat[i*DW +: DW]));
         e[i] = D_W'(signed'(in_mat[i*DW +: DW]));
      end
      tr = m[0] + m[4] + m[8];
      data_in.ctx.sel = SEL_W;
      if (tr > 0) begin
         data_in.ctx.sel = SEL_W;
      end else if (m[8] > ((m[4] > m[0]) ? m[4] : m[0])) begin
         data_in.ctx.sel = SEL_Z;
      end else if (m[4] > m[0]) begin
         data_in.ctx.sel = SEL_Y;
      end else begin
         data_in.ctx.sel = SEL_X;
      end
      case (data_in.ctx.sel)
         SEL_W: begin
            arg_s = tr + one_s;
            data_in.ctx.da = e[7] - e[5];
            data_in.ctx.db = e[2] - e[6];
            data_in.ctx.dc = e[3] - e[1];
         end
         SEL_X: begin
            arg_s = m[0] - m[4] - m[8] + one_s;
            data_in.ctx.da = e[7] - e[5];
            data_in.ctx.db = e[3] + e[1];
            data_in.ctx.dc = e[6] + e[2];
         end
         SEL_Y: begin
            arg_s = m[4] - m[8] - m[0] + one_s;
            data_in.ctx.da = e[2] - e[6];
            data_in.ctx.db = e[1] + e[3];
            data_in.ctx.dc = e[7] + e[5];
         end
         default: begin
            arg_s = m[8] - m[0] - m[4] + one_s;
            data_in.ctx.da = e[3] - e[1];
            data_in.ctx.db = e[2] + e[6];
            data_in.ctx.dc = e[5] + e[7];
         end
      endcase
      // clamp a negative argument to zero
      data_in.arg = arg_s[SUM_W-1] ? '0 : arg_s[ARG_W-1:0];
   end

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

[rtl/qfr_sqrt.sv]
`default_nettype none
module qfr_sqrt
   import qfr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire front_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output root_type       out_data
);

   logic [ROOT_W-1:0] v_ff;
   logic [ROOT_W-1:0] en;
   sq_state_type      st_ff [ROOT_W];
   sq_state_type      init;

   assign init.rem  = '0;
   assign init.root = '0;
   assign init.rad  = RAD_W'(in_data.arg) << FRAC_BITS;
   assign init.ctx  = in_data.ctx;

   // a stage advances when empty or when the next one advances
   always_comb begin
      en[ROOT_W-1] = !v_ff[ROOT_W-1] || out_ready;
      for (int s = ROOT_W - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      sq_state_type prev;
      logic         prev_v;
      if (s == 0) begin : g_first
         assign prev   = init;
         assign prev_v = in_valid;
      end else begin : g_next
         assign prev   = st_ff[s-1];
         assign prev_v = v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            st_ff[s] <= sqrt_step(prev);
         end
      end
   end

   assign in_ready      = en[0];
   assign out_valid     = v_ff[ROOT_W-1];
   assign out_data.root = st_ff[ROOT_W-1].root;
   assign out_data.ctx  = st_ff[ROOT_W-1].ctx;

endmodule
`default_nettype wire

[rtl/qfr_div.sv]
`default_nettype none
module qfr_div
   import qfr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire root_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output quo_type       out_data
);

   localparam int NST = QB + 1;

   logic [NST-1:0]        v_ff;
   logic [NST-1:0]        en;
   div_state_type         st_ff [NST];
   div_state_type         prep;
   logic signed [D_W-1:0] d [3];
   logic [D_W-1:0]        mag;
   logic [NUM_W-1:0]      num;
   logic [CMP_W-1:0]      hi;
   logic [CMP_W-1:0]      dd;

   assign d[0] = in_data.ctx.da;
   assign d[1] = in_data.ctx.db;
   assign d[2] = in_data.ctx.dc;

   // numerator d * 2^F + r over divisor 2r, saturate early if the quotient is wide
   always_comb begin
      prep.dvs  = {in_data.root, 1'b0};
      prep.root = in_data.root;
      prep.sel  = in_data.ctx.sel;
      dd        = CMP_W'(prep.dvs);
      mag       = '0;
      num       = '0;
      hi        = '0;
      for (int i = 0; i < 3; i++) begin
         mag = d[i][D_W-1] ? D_W'(-d[i]) : D_W'(d[i]);
         num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(in_data.root);
         hi  = CMP_W'(num >> QB);
         prep.lane[i].neg    = d[i][D_W-1];
         prep.lane[i].ovf    = (hi >= dd);
         prep.lane[i].rem    = {1'b0, hi[DIV_W-1:0]};
         prep.lane[i].num_lo = num[QB-1:0];
         prep.lane[i].quo    = '0;
      end
   end

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || out_ready;
      for (int s = NST - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   for (genvar s = 0; s < NST; s++) begin : g_stage
      div_state_type nxt;
      logic          prev_v;
      if (s == 0) begin : g_first
         assign nxt    = prep;
         assign prev_v = in_valid;
      end else begin : g_next
         always_comb begin
            nxt = st_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               nxt.lane[i] = div_step(st_ff[s-1].lane[i], st_ff[s-1].dvs);
            end
         end
         assign prev_v = v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            st_ff[s] <= nxt;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NST-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_data.quo[i] = st_ff[NST-1].lane[i].quo;
         out_data.ovf[i] = st_ff[NST-1].lane[i].ovf;
         out_data.neg[i] = st_ff[NST-1].lane[i].neg;
      end
      out_data.root = st_ff[NST-1].root;
      out_data.sel  = st_ff[NST-1].sel;
   end

endmodule
`default_nettype wire

[rtl/quaternion_from_rotation_matrix_top.sv]
`default_nettype none
// Rotation matrix to unit quaternion. Each req_ beat carries one 3x3 matrix, row
// major, as nine signed Q1.14 values; each rsp_ beat returns (w, x, y, z) in the same
// format plus a degenerate flag in rsp_tuser. With a positive trace, w comes from
// the root of trace+1; otherwise the largest diagonal element (ties favor m00, then
// m11) picks the part taken from the root, and the other three are off-diagonal sums
// or differences divided by twice the root, rounded to nearest with ties away from
// zero. A negative root argument is clamped to zero; a zero root returns identity and
// raises degenerate. All parts saturate to 16 bits. A new matrix is taken every cycle
// unless a stall has filled the pipeline: one select stage, 16 root stages (one root
// bit each), one divide setup stage, 17 divide stages (one quotient bit each, three
// dividers side by side) and the output register. Every stage holds while stalled and
// fills bubbles, so rsp_tready low only stalls req_tready once the pipeline is full.
module quaternion_from_rotation_matrix_top
   import qfr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
   input  wire logic [143:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // qw, qx, qy, qz (16 bits each)
   output logic [63:0]       rsp_tdata,
   // degenerate
   output logic [0:0]        rsp_tuser
);

   logic      fr_valid;
   logic      fr_ready;
   front_type fr_data;
   logic      sq_valid;
   logic      sq_ready;
   root_type  sq_data;
   logic      dv_valid;
   logic      dv_ready;
   quo_type   dv_data;

   logic                  out_v_ff;
   logic [3:0][DW-1:0]    q_ff;
   logic [3:0][DW-1:0]    q_in;
   logic                  deg_ff;
   logic                  deg_in;
   logic [DW-1:0]         other [3];
   logic [ROOT_W:0]       rh;
   logic [HALF_W-1:0]     half;
   logic [DW-1:0]         rpart;

   qfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mat    (req_tdata),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   qfr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_data  (sq_data)
   );

   qfr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_data   (sq_data),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_data  (dv_data)
   );

   // root part is r/2 rounded half up; place it and the three quotients
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         other[i] = sat_quo(dv_data.quo[i], dv_data.ovf[i], dv_data.neg[i]);
      end
      rh     = {1'b0, dv_data.root} + (ROOT_W + 1)'(1);
      half   = HALF_W'(rh[ROOT_W:1]);
      rpart  = (half > HPOS_LIM) ? SAT_MAX : half[DW-1:0];
      deg_in = (dv_data.root == '0);
      case (dv_data.sel)
         SEL_W:   q_in = {other[2], other[1], other[0], rpart};
         SEL_X:   q_in = {other[2], other[1], rpart, other[0]};
         SEL_Y:   q_in = {other[2], rpart, other[1], other[0]};
         default: q_in = {rpart, other[2], other[1], other[0]};
      endcase
      // zero root: identity
      if (deg_in) begin
         q_in = {DW'(0), DW'(0), DW'(0), ONE_SAT};
      end
   end

   // output register: hold while the sink stalls, refill as soon as it takes the beat
   assign dv_ready = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (dv_ready) begin
         out_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready) begin
         q_ff   <= q_in;
         deg_ff <= deg_in;
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = q_ff;
   assign rsp_tuser[0] = deg_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_deg_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[63:16] == '0)
      else $error("degenerate result has nonzero vector part");

   a_deg_w: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[15:0] == ONE_SAT)
      else $error("degenerate result is not identity");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_tready |-> !dv_ready)
      else $error("divider drained into a stalled output register");
`endif

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import qfr_pkg::*;

   localparam int LATENCY   = 36;
   localparam int CYCLE_MAX = 400000;

   typedef struct packed {
      logic [15:0] qw;
      logic [15:0] qx;
      logic [15:0] qy;
      logic [15:0] qz;
      logic        degen;
   } quat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   quat_type quat_expected[$];
   int    error_count  = 0;
   int    matrix_count = 0;
   int    quat_count   = 0;
   int    degen_count  = 0;
   int    cycle_count  = 0;
   int    send_idle_pct = 0;
   int    recv_stall_pct = 0;
   bit    recv_hold = 1'b0;

   quaternion_from_rotation_matrix_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Saturate a wide value to one 16-bit part
   function automatic logic [15:0] clip16(input longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   // Integer square root by bisection on a 64-bit radicand
   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd4294967295;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // d * 2^FRAC / (2r), nearest, ties away from zero
   function automatic longint round_div(input longint d, input longint unsigned r);
      longint unsigned mag, q;
      mag = (d < 0) ? -d : d;
      q   = ((mag << FRAC_BITS) + r) / (2 * r);
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Predict the quaternion for one matrix
   function automatic quat_type matrix_to_quat(input logic [143:0] mat);
      quat_type        q;
      longint          m[9];
      longint          one, arg, p[4];
      longint unsigned r, half;
      sel_type         sel;
      bit              by_trace;
      one = longint'(1) << FRAC_BITS;
      for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[16*i +: 16]));
      by_trace = (m[0] + m[4] + m[8]) > 0;
      sel = SEL_X;
      if (by_trace) begin
         sel = SEL_W;
         arg = m[0] + m[4] + m[8] + one;
      end else begin
         if (m[4] > m[0]) sel = SEL_Y;
         if (m[8] > ((sel == SEL_Y) ? m[4] : m[0])) sel = SEL_Z;
         case (sel)
            SEL_X: arg = m[0] - m[4] - m[8] + one;
            SEL_Y: arg = m[4] - m[8] - m[0] + one;
            default: arg = m[8] - m[0] - m[4] + one;
         endcase
      end
      if (arg < 0) arg = 0;
      r = int_root(longint'(arg) << FRAC_BITS);
      if (r == 0) begin
         q.qw = clip16(one);
         q.qx = '0;
         q.qy = '0;
         q.qz = '0;
         q.degen = 1'b1;
         return q;
      end
      half = (r + 1) >> 1;
      case (sel)
         SEL_W: begin
            p[0] = half;
            p[1] = round_div(m[7] - m[5], r);
            p[2] = round_div(m[2] - m[6], r);
            p[3] = round_div(m[3] - m[1], r);
         end
         SEL_X: begin
            p[1] = half;
            p[0] = round_div(m[7] - m[5], r);
            p[2] = round_div(m[3] + m[1], r);
            p[3] = round_div(m[6] + m[2], r);
         end
         SEL_Y: begin
            p[2] = half;
            p[0] = round_div(m[2] - m[6], r);
            p[3] = round_div(m[7] + m[5], r);
            p[1] = round_div(m[1] + m[3], r);
         end
         default: begin
            p[3] = half;
            p[0] = round_div(m[3] - m[1], r);
            p[1] = round_div(m[2] + m[6], r);
            p[2] = round_div(m[5] + m[7], r);
         end
      endcase
      q.qw = clip16(p[0]);
      q.qx = clip16(p[1]);
      q.qy = clip16(p[2]);
      q.qz = clip16(p[3]);
      q.degen = 1'b0;
      return q;
   endfunction

   // Pack nine elements, m00 in the lowest bits
   function automatic logic [143:0] pack_matrix(input int e[9]);
      logic [143:0] v;
      for (int i = 0; i < 9; i++) v[16*i +: 16] = 16'(e[i]);
      return v;
   endfunction

   // Send one matrix beat, idling at random first; valid stays high across beats
   task automatic send_matrix(input logic [143:0] mat);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mat;
      do @(posedge clock); while (!req_tready);
      quat_expected.push_back(matrix_to_quat(mat));
      matrix_count++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // Wait until every predicted quaternion has come back
   task automatic drain();
      stop_sending();
      while (quat_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset || recv_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each returned beat with the oldest prediction
   always @(posedge clock) begin
      quat_type want;
      quat_type got;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.qw = rsp_tdata[15:0];
         got.qx = rsp_tdata[31:16];
         got.qy = rsp_tdata[47:32];
         got.qz = rsp_tdata[63:48];
         got.degen = rsp_tuser[0];
         if (quat_expected.size() == 0) begin
            $display("%0t: unexpected beat %h/%b", $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = quat_expected.pop_front();
            quat_count++;
            if (want.degen) degen_count++;
            if (got != want) begin
               $display("%0t: mismatch expected w=%h x=%h y=%h z=%h d=%b", $time,
                        want.qw, want.qx, want.qy, want.qz, want.degen);
               $display("%0t:          actual   w=%h x=%h y=%h z=%h d=%b", $time,
                        got.qw, got.qx, got.qy, got.qz, got.degen);
               error_count++;
            end
         end
      end
      if (cycle_count > CYCLE_MAX) begin
         $display("%0t: timeout, %0d beats outstanding", $time, quat_expected.size());
         $display("** quaternion_from_rotation_matrix_top: FAILED **");
         $finish;
      end
   end

   // Random element, biased toward the rotation range and the extremes
   function automatic int rand_elem();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? 32767 : -32768;
         1: return int'($urandom_range(65535)) - 32768;
         default: return int'($urandom_range(32768)) - 16384;
      endcase
   endfunction

   // Random matrix: one diagonal element made the largest, a diagonal tie, or all random
   function automatic logic [143:0] rand_matrix();
      int e[9];
      int pick;
      for (int i = 0; i < 9; i++) e[i] = rand_elem();
      pick = $urandom_range(5);
      if (pick < 3) begin
         // make one diagonal element the largest, the other two zero or negative
         e[4*pick] = 16384 - int'($urandom_range(4096));
         e[4*((pick+1)%3)] = -int'($urandom_range(16384));
         e[4*((pick+2)%3)] = -int'($urandom_range(16384));
      end else if (pick == 3) begin
         // tie among diagonal elements
         e[4] = e[0];
         if ($urandom_range(1)) e[8] = e[0];
      end
      return pack_matrix(e);
   endfunction

   task automatic test_directed();
      int e[9];
      int diag[4] = '{16384, -16384, 32767, -32768};
      // identity, trace path
      e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
      send_matrix(pack_matrix(e));
      // 180 degrees about x, y and z: each diagonal wins once
      e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
      send_matrix(pack_matrix(e));
      e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
      send_matrix(pack_matrix(e));
      e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
      send_matrix(pack_matrix(e));
      // all zero: trace not positive, ties pick m00
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(pack_matrix(e));
      // equal negative full-scale diagonal: three-way tie picks m00
      e = '{-32768, 5, 7, 9, -32768, 11, 13, 15, -32768};
      send_matrix(pack_matrix(e));
      // m11 and m22 tie above m00
      e = '{-16384, 100, -200, 300, 0, 400, -500, 600, 0};
      send_matrix(pack_matrix(e));
      // full-scale elements; the last one saturates x, y and z
      e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
      send_matrix(pack_matrix(e));
      e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
      send_matrix(pack_matrix(e));
      e = '{1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0};
      send_matrix(pack_matrix(e));
      // large off-diagonals with a negative trace
      e = '{-16383, 32767, -32768, -32768, -1, 32767, 32767, -32768, 0};
      send_matrix(pack_matrix(e));
      e = '{0, -32768, 32767, 32767, 1, -32768, -32768, 32767, -16384};
      send_matrix(pack_matrix(e));
      // ties between m11 and m22
      e = '{-20000, 3, 4, 5, -100, 6, 7, 8, -100};
      send_matrix(pack_matrix(e));
      foreach (diag[i]) begin
         for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? diag[i] : diag[(i+k)%4];
         send_matrix(pack_matrix(e));
      end
      drain();
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_matrix(rand_matrix());
      drain();
   endtask

   // Hold the receiver off long enough to fill the pipeline and stall input
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            recv_hold = 1'b1;
            repeat (3 * LATENCY) @(posedge clock);
            recv_hold = 1'b0;
         end
         repeat (100) send_matrix(rand_matrix());
      join
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250, 0, 0);
      test_random(250, 64, 0);
      test_random(250, 0, 64);
      test_random(250, 32, 32);
      test_backpressure();
      $display("Covered %0d matrices, %0d quaternions checked, %0d degenerate,",
               matrix_count, quat_count, degen_count);
      $display("under idle, stall and long back-pressure phases.");
      if (error_count == 0) begin
         $display("** quaternion_from_rotation_matrix_top: PASSED **");
      end else begin
         $display("** quaternion_from_rotation_matrix_top: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
rtl/qfr_pkg.sv
rtl/qfr_front.sv
rtl/qfr_sqrt.sv
rtl/qfr_div.sv
rtl/quaternion_from_rotation_matrix_top.sv
verif/testbench.sv
